[rtl/core/morse_text_encoder_assert.svh]
// ----------------------------------------------------------------------------
// morse text encoder assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MORSE_TEXT_ENCODER_ASSERT_SVH
`define MORSE_TEXT_ENCODER_ASSERT_SVH

// same-cycle implication
`define MTE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MTE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/mte_pkg.sv]
// ----------------------------------------------------------------------------
// mte_pkg
// shared types, symbol codes and the character to morse pattern table
// ----------------------------------------------------------------------------
`default_nettype none

package mte_pkg;

   // output symbol codes
   typedef enum logic [1:0] {
      SYM_DOT   = 2'd0,
      SYM_DASH  = 2'd1,
      SYM_SPACE = 2'd2,
      SYM_SLASH = 2'd3
   } symbol_type;

   // longest dot/dash pattern and longest symbol run per character
   localparam int unsigned PatMaxC = 6;
   localparam int unsigned RunMaxC = 7;

   // ascii codes with special handling
   localparam logic [7:0] AsciiSpaceC = 8'h20;
   localparam logic [7:0] CaseOffsetC = 8'h20;

   // pattern: bits left-aligned, first symbol in the msb, 1 = dash
   typedef struct packed {
      logic       valid;
      logic [2:0] len;
      logic [5:0] bits;
   } pattern_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic shift;
   } mte_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic load_nonempty;
      logic on_last;
   } mte_status_type;

   function automatic pattern_type pattern_of(input logic [7:0] code);
      logic [7:0]  c;
      pattern_type p;
      c = code;
      if (c inside {["a":"z"]}) begin
         c = c - CaseOffsetC;
      end
      p = '{valid: 1'b1, len: 3'd0, bits: 6'b000000};
      case (c)
         "A":  begin p.len = 3'd2; p.bits = 6'b010000; end
         "B":  begin p.len = 3'd4; p.bits = 6'b100000; end
         "C":  begin p.len = 3'd4; p.bits = 6'b101000; end
         "D":  begin p.len = 3'd3; p.bits = 6'b100000; end
         "E":  begin p.len = 3'd1; p.bits = 6'b000000; end
         "F":  begin p.len = 3'd4; p.bits = 6'b001000; end
         "G":  begin p.len = 3'd3; p.bits = 6'b110000; end
         "H":  begin p.len = 3'd4; p.bits = 6'b000000; end
         "I":  begin p.len = 3'd2; p.bits = 6'b000000; end
         "J":  begin p.len = 3'd4; p.bits = 6'b011100; end
         "K":  begin p.len = 3'd3; p.bits = 6'b101000; end
         "L":  begin p.len = 3'd4; p.bits = 6'b010000; end
         "M":  begin p.len = 3'd2; p.bits = 6'b110000; end
         "N":  begin p.len = 3'd2; p.bits = 6'b100000; end
         "O":  begin p.len = 3'd3; p.bits = 6'b111000; end
         "P":  begin p.len = 3'd4; p.bits = 6'b011000; end
         "Q":  begin p.len = 3'd4; p.bits = 6'b110100; end
         "R":  begin p.len = 3'd3; p.bits = 6'b010000; end
         "S":  begin p.len = 3'd3; p.bits = 6'b000000; end
         "T":  begin p.len = 3'd1; p.bits = 6'b100000; end
         "U":  begin p.len = 3'd3; p.bits = 6'b001000; end
         "V":  begin p.len = 3'd4; p.bits = 6'b000100; end
         "W":  begin p.len = 3'd3; p.bits = 6'b011000; end
         "X":  begin p.len = 3'd4; p.bits = 6'b100100; end
         "Y":  begin p.len = 3'd4; p.bits = 6'b101100; end
         "Z":  begin p.len = 3'd4; p.bits = 6'b110000; end
         "0":  begin p.len = 3'd5; p.bits = 6'b111110; end
         "1":  begin p.len = 3'd5; p.bits = 6'b011110; end
         "2":  begin p.len = 3'd5; p.bits = 6'b001110; end
         "3":  begin p.len = 3'd5; p.bits = 6'b000110; end
         "4":  begin p.len = 3'd5; p.bits = 6'b000010; end
         "5":  begin p.len = 3'd5; p.bits = 6'b000000; end
         "6":  begin p.len = 3'd5; p.bits = 6'b100000; end
         "7":  begin p.len = 3'd5; p.bits = 6'b110000; end
         "8":  begin p.len = 3'd5; p.bits = 6'b111000; end
         "9":  begin p.len = 3'd5; p.bits = 6'b111100; end
         ".":  begin p.len = 3'd6; p.bits = 6'b010101; end
         ",":  begin p.len = 3'd6; p.bits = 6'b110011; end
         "?":  begin p.len = 3'd6; p.bits = 6'b001100; end
         "'":  begin p.len = 3'd6; p.bits = 6'b011110; end
         "\"": begin p.len = 3'd6; p.bits = 6'b010010; end
         "!":  begin p.len = 3'd6; p.bits = 6'b101011; end
         "/":  begin p.len = 3'd5; p.bits = 6'b100100; end
         "(":  begin p.len = 3'd5; p.bits = 6'b101100; end
         ")":  begin p.len = 3'd6; p.bits = 6'b101101; end
         "&":  begin p.len = 3'd5; p.bits = 6'b010000; end
         default: begin
            p.valid = 1'b0;
         end
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

[rtl/core/mte_ctrl.sv]
// ----------------------------------------------------------------------------
// mte_ctrl
// controller: accepts one character, then hands out its symbols one by one
// ----------------------------------------------------------------------------
`default_nettype none

`include "morse_text_encoder_assert.svh"

module mte_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire mte_pkg::mte_status_type status,
   output mte_pkg::mte_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // handshake outputs follow the state
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.shift = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.load_nonempty) begin
                  state_in = ST_SEND;
               end
            end
         end
         ST_SEND: begin
            if (rsp_ready) begin
               cmd.shift = 1'b1;
               if (status.on_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `MTE_ASSERT_NEXT(a_last_frees_input, rsp_valid && rsp_ready && status.on_last, req_ready, "input not ready after last symbol")
   `MTE_ASSERT_NEXT(a_load_starts_send, req_valid && req_ready && status.load_nonempty, rsp_valid, "no symbol after a character with a pattern")
   `MTE_ASSERT_NEXT(a_silent_stays_idle, req_valid && req_ready && !status.load_nonempty, req_ready && !rsp_valid, "silent character left the idle state")

endmodule

`default_nettype wire

[rtl/core/mte_datapath.sv]
// ----------------------------------------------------------------------------
// mte_datapath
// datapath: pattern lookup, symbol run shift register and space tracking
// ----------------------------------------------------------------------------
`default_nettype none

`include "morse_text_encoder_assert.svh"

module mte_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           req_char_code,
   input  wire logic                 req_end_of_text,
   input  wire mte_pkg::mte_cmd_type cmd,
   output mte_pkg::mte_status_type   status,
   output logic [1:0]                rsp_symbol,
   output logic                      rsp_last_of_run
);

   localparam int unsigned RunW = 2 * mte_pkg::RunMaxC;

   mte_pkg::pattern_type pat;
   logic                 is_space;
   logic [2:0]           count_in;
   logic [2:0]           count_ff;
   logic [RunW-1:0]      run_in;
   logic [RunW-1:0]      run_ff;
   logic                 prev_space_in;
   logic                 prev_space_ff;

   assign pat      = mte_pkg::pattern_of(req_char_code);
   assign is_space = (req_char_code == mte_pkg::AsciiSpaceC);

   // build the symbol run of a new character, first symbol in the low slot
   always_comb begin
      run_in   = '0;
      count_in = 3'd0;
      if (pat.valid) begin
         for (int i = 0; i < int'(mte_pkg::RunMaxC); i++) begin
            if ((i < int'(mte_pkg::PatMaxC)) && (3'(i) < pat.len)) begin
               run_in[2*i +: 2] = pat.bits[mte_pkg::PatMaxC - 1 - i] ?
                                  mte_pkg::SYM_DASH : mte_pkg::SYM_DOT;
            end else if (3'(i) == pat.len) begin
               run_in[2*i +: 2] = mte_pkg::SYM_SPACE;
            end
         end
         count_in = pat.len + {2'b00, !req_end_of_text};
      end else if (is_space && !prev_space_ff) begin
         run_in[1:0] = mte_pkg::SYM_SLASH;
         run_in[3:2] = mte_pkg::SYM_SPACE;
         count_in    = 3'd1 + {2'b00, !req_end_of_text};
      end
   end

   assign prev_space_in = is_space && !req_end_of_text;

   // status for the controller
   assign status.load_nonempty = (count_in != 3'd0);
   assign status.on_last       = (count_ff == 3'd1);

   // head of the run drives the result transaction
   assign rsp_symbol      = run_ff[1:0];
   assign rsp_last_of_run = (count_ff == 3'd1);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= 3'd0;
         prev_space_ff <= 1'b0;
      end else if (cmd.load) begin
         count_ff      <= count_in;
         prev_space_ff <= prev_space_in;
      end else if (cmd.shift) begin
         count_ff      <= count_ff - 3'd1;
      end
   end

   // symbol run shift register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         run_ff <= run_in;
      end else if (cmd.shift) begin
         run_ff <= {2'b00, run_ff[RunW-1:2]};
      end
   end

   // checks
   `MTE_ASSERT_SAME(a_shift_needs_symbol, cmd.shift, count_ff != 3'd0, "shift with an empty run")
   `MTE_ASSERT_SAME(a_one_command, cmd.load, !cmd.shift, "load and shift in the same cycle")
   `MTE_ASSERT_NEXT(a_last_empties_run, cmd.shift && (count_ff == 3'd1), count_ff == 3'd0, "run not empty after its last symbol")

endmodule

`default_nettype wire

[rtl/core/morse_text_encoder.sv]
// ----------------------------------------------------------------------------
// morse_text_encoder
// international morse code encoder, one ascii character in, one symbol out
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one ascii character per transaction, with an end of text
//   flag on the last character of a text.
//   rsp_ channel: one symbol per transaction (dot, dash, space separator,
//   word slash); rsp_last_of_run marks the final symbol of a character.
//   the first symbol is shown the cycle after the character is taken; the
//   symbol shift register hands out one symbol per cycle while the receiver
//   is ready, and a character that gives no symbol leaves the block ready
//   for the next character.
//   req_ready is high only while no symbol of the previous character waits.
//   a stalled receiver holds the current symbol on the rsp_ ports until taken.
//   reset: clears the symbol count and the previous-space flag, so the first
//   character counts as following a non-space.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_text_encoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_symbol,
   output logic            rsp_last_of_run
);

   mte_pkg::mte_cmd_type    cmd;
   mte_pkg::mte_status_type status;

   // controller
   mte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   mte_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .cmd             (cmd),
      .status          (status),
      .rsp_symbol      (rsp_symbol),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// checks morse_text_encoder against its own symbol predictor: a directed
// table of characters covering the edge cases, then random text under
// several idling and back-pressure patterns, every symbol compared in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   timeunit 1ns;
   timeprecision 1ps;

   // one row of the directed table; typed rows carry their own expectation
   typedef struct packed {
      logic [7:0]  code;
      logic        eot;
      logic        typed;
      logic [2:0]  n;
      logic [13:0] syms;
   } text_row_type;

   // one expected symbol transaction
   typedef struct packed {
      mte_pkg::symbol_type sym;
      logic                last;
   } symbol_slot_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_code = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_symbol;
   logic       rsp_last_of_run;

   symbol_slot_type pending_symbols[$];
   logic            prev_space = 1'b0;
   int              mismatches = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              hold_asked = 0;

   localparam int NumRows = 25;
   localparam int HoldCycles = 300;

   text_row_type char_rows [NumRows] = '{
      '{8'h20, 1'b0, 1'b1, 3'd2, {mte_pkg::SYM_SLASH, mte_pkg::SYM_SPACE, 10'b0}},
      '{8'h20, 1'b0, 1'b1, 3'd0, 14'b0},
      '{"a",   1'b0, 1'b0, 3'd0, 14'b0},
      '{"Z",   1'b0, 1'b0, 3'd0, 14'b0},
      '{8'h00, 1'b0, 1'b1, 3'd0, 14'b0},
      '{8'h20, 1'b0, 1'b0, 3'd0, 14'b0},
      '{8'hFF, 1'b0, 1'b1, 3'd0, 14'b0},
      '{8'h20, 1'b0, 1'b0, 3'd0, 14'b0},
      '{"\"",  1'b0, 1'b0, 3'd0, 14'b0},
      '{"'",   1'b0, 1'b0, 3'd0, 14'b0},
      '{".",   1'b0, 1'b0, 3'd0, 14'b0},
      '{",",   1'b0, 1'b1, 3'd7,
        {mte_pkg::SYM_DASH, mte_pkg::SYM_DASH, mte_pkg::SYM_DOT, mte_pkg::SYM_DOT,
         mte_pkg::SYM_DASH, mte_pkg::SYM_DASH, mte_pkg::SYM_SPACE}},
      '{"?",   1'b0, 1'b0, 3'd0, 14'b0},
      '{"!",   1'b0, 1'b0, 3'd0, 14'b0},
      '{"/",   1'b0, 1'b0, 3'd0, 14'b0},
      '{"(",   1'b0, 1'b0, 3'd0, 14'b0},
      '{")",   1'b0, 1'b0, 3'd0, 14'b0},
      '{"&",   1'b0, 1'b0, 3'd0, 14'b0},
      '{"0",   1'b0, 1'b0, 3'd0, 14'b0},
      '{"9",   1'b0, 1'b0, 3'd0, 14'b0},
      '{"m",   1'b0, 1'b0, 3'd0, 14'b0},
      '{"E",   1'b1, 1'b1, 3'd1, {mte_pkg::SYM_DOT, 12'b0}},
      '{8'h20, 1'b1, 1'b1, 3'd1, {mte_pkg::SYM_SLASH, 12'b0}},
      '{8'h20, 1'b0, 1'b1, 3'd2, {mte_pkg::SYM_SLASH, mte_pkg::SYM_SPACE, 10'b0}},
      '{".",   1'b1, 1'b1, 3'd6,
        {mte_pkg::SYM_DOT, mte_pkg::SYM_DASH, mte_pkg::SYM_DOT, mte_pkg::SYM_DASH,
         mte_pkg::SYM_DOT, mte_pkg::SYM_DASH, 2'b0}}
   };

   morse_text_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // clock and reset
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // dot/dash pattern of an upper-case character, empty when it has none
   function automatic string morse_of(input logic [7:0] c);
      case (c)
         "A": return ".-";     "B": return "-...";   "C": return "-.-.";
         "D": return "-..";    "E": return ".";      "F": return "..-.";
         "G": return "--.";    "H": return "....";   "I": return "..";
         "J": return ".---";   "K": return "-.-";    "L": return ".-..";
         "M": return "--";     "N": return "-.";     "O": return "---";
         "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
         "S": return "...";    "T": return "-";      "U": return "..-";
         "V": return "...-";   "W": return ".--";    "X": return "-..-";
         "Y": return "-.--";   "Z": return "--..";
         "0": return "-----";  "1": return ".----";  "2": return "..---";
         "3": return "...--";  "4": return "....-";  "5": return ".....";
         "6": return "-....";  "7": return "--...";  "8": return "---..";
         "9": return "----.";
         ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--..";
         "'": return ".----."; "\"": return ".-..-."; "!": return "-.-.--";
         "/": return "-..-.";  "(": return "-.--.";  ")": return "-.--.-";
         "&": return ".-...";
         default: return "";
      endcase
   endfunction

   // symbols that one character produces; advances the previous-space flag
   function automatic void encode_char(input logic [7:0] c, input logic eot,
                                       output logic [2:0] n,
                                       output logic [13:0] syms);
      string      pat;
      logic [7:0] upper;
      int         i;
      upper = (c >= "a" && c <= "z") ? c - 8'h20 : c;
      pat = morse_of(upper);
      n = 3'd0;
      syms = '0;
      if (pat.len() > 0) begin
         for (i = 0; i < pat.len(); i++) begin
            syms[13 - 2 * i -: 2] = (pat[i] == "-") ? mte_pkg::SYM_DASH : mte_pkg::SYM_DOT;
            n++;
         end
         if (!eot) begin
            syms[13 - 2 * n -: 2] = mte_pkg::SYM_SPACE;
            n++;
         end
      end else if (c == 8'h20 && !prev_space) begin
         syms[13:12] = mte_pkg::SYM_SLASH;
         n = 3'd1;
         if (!eot) begin
            syms[11:10] = mte_pkg::SYM_SPACE;
            n = 3'd2;
         end
      end
      prev_space = (c == 8'h20) && !eot;
   endfunction

   // queue the symbols of one accepted character, last one flagged
   task automatic queue_symbols(input logic [2:0] n, input logic [13:0] syms);
      int i;
      for (i = 0; i < n; i++) begin
         pending_symbols.push_back(symbol_slot_type'{
            mte_pkg::symbol_type'(syms[13 - 2 * i -: 2]), i == n - 1});
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) begin
         $display("tb: mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   // offer one character, optionally after random idle cycles
   task automatic send_char(input logic [7:0] c, input logic eot,
                            output logic [2:0] n, output logic [13:0] syms);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_char_code = c;
      req_end_of_text = eot;
      do @(posedge clock); while (!req_ready);
      encode_char(c, eot, n, syms);
      @(negedge clock);
   endtask

   // random text: mostly letters, digits, punctuation and space runs
   task automatic send_random(input int count);
      logic [7:0]  c;
      logic [2:0]  n;
      logic [13:0] syms;
      int          pick;
      int          k;
      string       punct;
      punct = ".,?'\"!/()&";
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            c = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "a" : "A");
         end else if (pick < 50) begin
            c = 8'($urandom_range(0, 9)) + "0";
         end else if (pick < 65) begin
            c = punct[$urandom_range(0, 9)];
         end else if (pick < 85) begin
            c = 8'h20;
         end else begin
            c = 8'($urandom_range(0, 255));
         end
         send_char(c, $urandom_range(0, 11) == 0, n, syms);
         queue_symbols(n, syms);
      end
   endtask

   // receiver: random stalls plus a long hold-off on request
   initial begin
      int hold_left;
      int hold_served;
      hold_left = 0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = $urandom_range(0, 99) >= recv_stall_pct;
         end
      end
   end

   // symbol checker
   always @(posedge clock) begin
      symbol_slot_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_symbols.size() == 0) begin
            report_mismatch($sformatf("unexpected symbol %0d", rsp_symbol));
         end else begin
            want = pending_symbols.pop_front();
            if (rsp_symbol !== want.sym) begin
               report_mismatch($sformatf("symbol %0d, expected %s",
                                         rsp_symbol, want.sym.name()));
            end
            if (rsp_last_of_run !== want.last) begin
               report_mismatch($sformatf("last_of_run %b, expected %b",
                                         rsp_last_of_run, want.last));
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [2:0]  n;
      logic [13:0] syms;
      int          r;
      wait (!reset);
      @(negedge clock);

      // directed table, no idling
      for (r = 0; r < NumRows; r++) begin
         send_char(char_rows[r].code, char_rows[r].eot, n, syms);
         if (char_rows[r].typed) begin
            queue_symbols(char_rows[r].n, char_rows[r].syms);
         end else begin
            queue_symbols(n, syms);
         end
      end

      // random text under the idling patterns
      send_random(75);
      send_idle_pct = 73;
      send_random(70);
      send_idle_pct = 0;
      recv_stall_pct = 73;
      send_random(70);
      send_idle_pct = 31;
      recv_stall_pct = 31;
      send_random(70);

      // long receiver hold-off while the sender keeps offering
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_asked++;
      send_random(40);

      // drain
      req_valid = 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0 && pending_symbols.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

[morse_text_encoder.f]
+incdir+rtl/core
rtl/core/mte_pkg.sv
rtl/core/mte_ctrl.sv
rtl/core/mte_datapath.sv
rtl/core/morse_text_encoder.sv
bench/tb.sv
